@@ hw/rtl/mjd_to_calendar_date_unit_macros.svh @@
// Assertion macros used by the checker file of the date conversion unit.
`ifndef MJD_TO_CALENDAR_DATE_UNIT_MACROS_SVH
`define MJD_TO_CALENDAR_DATE_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define MJDCAL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("mjdcal check failed");

// Next-cycle implication, disabled while reset is held.
`define MJDCAL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("mjdcal check failed");

`endif

@@ hw/rtl/mjdcal_pkg.sv @@
// Types and constants of the MJD to calendar date unit.
package mjdcal_pkg;

    localparam int NUM_STAGES = 7;
    typedef logic [NUM_STAGES-1:0] t_stage_vec;

    // Field widths
    localparam int MJD_W   = 23;
    localparam int FRAC_W  = 32;
    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int HOUR_W  = 5;
    localparam int MIN_W   = 6;
    localparam int SEC_W   = 6;
    localparam int MSEC_W  = 10;

    localparam int FRACTION_BITS = 32;

    // ---- date path ----
    localparam int Z_W  = 24;       // julian day number, signed
    localparam int NA_W = 25;       // numerator of the century term
    localparam int AL_W = 8;        // century correction alpha
    localparam int B_W  = 25;
    localparam int NC_W = 30;       // biased numerator of the year term
    localparam int CQ_W = 15;
    localparam int C_W  = 16;
    localparam int X_W  = 9;        // day within the march-based year
    localparam int E_W  = 4;

    localparam int JD_OFFSET       = 2400001;
    localparam int GREGORIAN_START = 2299161;
    localparam int ALPHA_OFFSET    = 7468865;
    localparam int ALPHA_DIV       = 146097;
    localparam int B_OFFSET        = 1524;
    localparam int C_DIV           = 36525;
    localparam int C_BIAS          = 5000;   // keeps the year numerator positive
    localparam int C_NUM_OFFSET    = 100 * B_OFFSET - 12210 + C_BIAS * C_DIV;
    localparam int DAYS_4Y         = 1461;
    localparam int YEAR_OFF_LATE   = 4716;
    localparam int YEAR_OFF_EARLY  = 4715;
    localparam int MONTH_WRAP      = 14;

    localparam int S_ALPHA = NA_W + 18;
    localparam logic [63:0] M_ALPHA_FULL =
        ((64'd1 << S_ALPHA) + 64'(ALPHA_DIV) - 64'd1) / 64'(ALPHA_DIV);
    localparam logic [25:0] M_ALPHA = M_ALPHA_FULL[25:0];

    localparam int S_C = NC_W + 16;
    localparam logic [63:0] M_C_FULL =
        ((64'd1 << S_C) + 64'(C_DIV) - 64'd1) / 64'(C_DIV);
    localparam logic [30:0] M_C = M_C_FULL[30:0];

    // floor(30.6001 * k): days before month step k
    localparam logic [X_W-1:0] DAY_OFFSET [16] = '{
        9'd0,   9'd30,  9'd61,  9'd91,  9'd122, 9'd153, 9'd183, 9'd214,
        9'd244, 9'd275, 9'd306, 9'd336, 9'd367, 9'd397, 9'd428, 9'd459
    };

    // ---- time path ----
    localparam int MS_W    = 27;
    localparam int PROD_W  = FRAC_W + MS_W;
    localparam int QS_W    = 17;
    localparam int QM_W    = 11;
    localparam logic [MS_W-1:0] MS_PER_DAY = 27'd86400000;
    localparam logic [FRAC_W-1:0] FRAC_MASK = (FRACTION_BITS >= FRAC_W) ? '1 :
        FRAC_W'((64'd1 << FRACTION_BITS) - 64'd1);

    localparam int MS_PER_S  = 1000;
    localparam int S_PER_MIN = 60;
    localparam int MIN_PER_H = 60;

    localparam int S_MS_TO_S = MS_W + 10;
    localparam logic [63:0] M_MS_TO_S_FULL =
        ((64'd1 << S_MS_TO_S) + 64'(MS_PER_S) - 64'd1) / 64'(MS_PER_S);
    localparam logic [27:0] M_MS_TO_S = M_MS_TO_S_FULL[27:0];

    localparam int S_S_TO_MIN = QS_W + 6;
    localparam logic [63:0] M_S_TO_MIN_FULL =
        ((64'd1 << S_S_TO_MIN) + 64'(S_PER_MIN) - 64'd1) / 64'(S_PER_MIN);
    localparam logic [17:0] M_S_TO_MIN = M_S_TO_MIN_FULL[17:0];

    localparam int S_MIN_TO_H = QM_W + 6;
    localparam logic [63:0] M_MIN_TO_H_FULL =
        ((64'd1 << S_MIN_TO_H) + 64'(MIN_PER_H) - 64'd1) / 64'(MIN_PER_H);
    localparam logic [11:0] M_MIN_TO_H = M_MIN_TO_H_FULL[11:0];

endpackage

@@ hw/rtl/mjdcal_pipe_ctrl.sv @@
// Valid bits and per-stage load enables of the conversion pipeline.
module mjdcal_pipe_ctrl (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    output logic                    o_valid,
    input  logic                    i_stall,
    output mjdcal_pkg::t_stage_vec  o_load
);
    import mjdcal_pkg::*;

    t_stage_vec r_vld;
    t_stage_vec n_vld;
    t_stage_vec w_load;
    t_stage_vec w_shift;

    // A stage loads when it is empty or its successor loads: bubbles close up.
    always_comb begin
        w_load[NUM_STAGES-1] = !r_vld[NUM_STAGES-1] || !i_stall;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            w_load[k] = !r_vld[k] || w_load[k+1];
        end
        w_shift = {r_vld[NUM_STAGES-2:0], i_valid};
        for (int k = 0; k < NUM_STAGES; k++) begin
            n_vld[k] = w_load[k] ? w_shift[k] : r_vld[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_load  = w_load;
    assign o_stall = !w_load[0];
    assign o_valid = r_vld[NUM_STAGES-1];

endmodule

@@ hw/rtl/mjdcal_date_pipe.sv @@
// Date path: julian day number to year, month and day over seven stages.
module mjdcal_date_pipe (
    input  logic                                   i_clk,
    input  mjdcal_pkg::t_stage_vec                 i_load,
    input  logic signed [mjdcal_pkg::MJD_W-1:0]    i_mjd_day,
    output logic        [mjdcal_pkg::YEAR_W-1:0]   o_year,
    output logic        [mjdcal_pkg::MONTH_W-1:0]  o_month,
    output logic        [mjdcal_pkg::DAY_W-1:0]    o_day_of_month
);
    import mjdcal_pkg::*;

    // stage 1: julian day number, calendar select
    logic signed [Z_W-1:0]  w_z;
    logic                   w_greg;
    logic signed [Z_W+1:0]  w_n4;
    logic signed [Z_W-1:0]  r1_z;
    logic                   r1_greg;
    logic [NA_W-1:0]        r1_nalpha;

    assign w_z    = $signed({i_mjd_day[MJD_W-1], i_mjd_day}) + Z_W'(JD_OFFSET);
    assign w_greg = w_z >= Z_W'(GREGORIAN_START);
    assign w_n4   = $signed({w_z, 2'b00}) - (Z_W+2)'(ALPHA_OFFSET);

    always_ff @(posedge i_clk) begin
        if (i_load[0]) begin
            r1_z      <= w_z;
            r1_greg   <= w_greg;
            r1_nalpha <= w_greg ? w_n4[NA_W-1:0] : '0;
        end
    end

    // stage 2: alpha = floor(n / 146097) by reciprocal
    logic [NA_W+26-1:0]     w_pa;
    logic signed [Z_W-1:0]  r2_z;
    logic                   r2_greg;
    logic [AL_W-1:0]        r2_alpha;

    assign w_pa = (NA_W+26)'(r1_nalpha) * (NA_W+26)'(M_ALPHA);

    always_ff @(posedge i_clk) begin
        if (i_load[1]) begin
            r2_z     <= r1_z;
            r2_greg  <= r1_greg;
            r2_alpha <= w_pa[S_ALPHA +: AL_W];
        end
    end

    // stage 3: corrected day a, b = a + 1524, biased year numerator
    logic signed [B_W-1:0]  w_zx;
    logic signed [B_W-1:0]  w_a;
    logic signed [31:0]     w_nc;
    logic signed [B_W-1:0]  r3_b;
    logic [NC_W-1:0]        r3_nc;

    assign w_zx = $signed({r2_z[Z_W-1], r2_z});
    assign w_a  = r2_greg ? (w_zx + B_W'(1) + $signed({17'd0, r2_alpha})
                             - $signed({19'd0, r2_alpha[AL_W-1:2]}))
                          : w_zx;
    assign w_nc = $signed({{(32-B_W){w_a[B_W-1]}}, w_a}) * 32'sd100 + 32'(C_NUM_OFFSET);

    always_ff @(posedge i_clk) begin
        if (i_load[2]) begin
            r3_b  <= w_a + B_W'(B_OFFSET);
            r3_nc <= w_nc[NC_W-1:0];
        end
    end

    // stage 4: c = floor((100b - 12210) / 36525)
    logic [NC_W+31-1:0]     w_pc;
    logic [CQ_W-1:0]        w_cq;
    logic signed [B_W-1:0]  r4_b;
    logic signed [C_W-1:0]  r4_c;

    assign w_pc = (NC_W+31)'(r3_nc) * (NC_W+31)'(M_C);
    assign w_cq = w_pc[S_C +: CQ_W];

    always_ff @(posedge i_clk) begin
        if (i_load[3]) begin
            r4_b <= r3_b;
            r4_c <= $signed({1'b0, w_cq}) - C_W'(C_BIAS);
        end
    end

    // stage 5: x = b - floor(1461c / 4)
    logic signed [26:0]     w_dp;
    logic signed [26:0]     w_d;
    logic signed [26:0]     w_x;
    logic [X_W-1:0]         r5_x;
    logic signed [C_W-1:0]  r5_c;

    assign w_dp = $signed({{(27-C_W){r4_c[C_W-1]}}, r4_c}) * 27'(DAYS_4Y);
    assign w_d  = w_dp >>> 2;
    assign w_x  = $signed({{(27-B_W){r4_b[B_W-1]}}, r4_b}) - w_d;

    always_ff @(posedge i_clk) begin
        if (i_load[4]) begin
            r5_x <= w_x[X_W-1:0];
            r5_c <= r4_c;
        end
    end

    // stage 6: month step e; offsets rise, so the compares form a thermometer
    logic [16:0]            w_gt;
    logic [15:0]            w_oh;
    logic [E_W-1:0]         w_e;
    logic [X_W-1:0]         w_fsel;
    logic [E_W-1:0]         r6_e;
    logic [X_W-1:0]         r6_x;
    logic [X_W-1:0]         r6_fsel;
    logic signed [C_W-1:0]  r6_c;

    always_comb begin
        w_gt[16] = 1'b0;
        for (int k = 0; k < 16; k++) begin
            w_gt[k] = r5_x > DAY_OFFSET[k];
        end
        w_e    = '0;
        w_fsel = '0;
        for (int k = 0; k < 16; k++) begin
            w_oh[k] = w_gt[k] && !w_gt[k+1];
            w_e     = w_e | (w_oh[k] ? E_W'(k) : '0);
            w_fsel  = w_fsel | (w_oh[k] ? DAY_OFFSET[k] : '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load[5]) begin
            r6_e    <= w_e;
            r6_x    <= r5_x;
            r6_fsel <= w_fsel;
            r6_c    <= r5_c;
        end
    end

    // stage 7: day, month, year
    logic [X_W-1:0]         w_day;
    logic [MONTH_W-1:0]     w_month;
    logic signed [C_W-1:0]  w_year;
    logic [YEAR_W-1:0]      r_year;
    logic [MONTH_W-1:0]     r_month;
    logic [DAY_W-1:0]       r_day;

    assign w_day   = r6_x - r6_fsel;
    assign w_month = (r6_e < E_W'(MONTH_WRAP)) ? (r6_e - 4'd1) : (r6_e - 4'd13);
    assign w_year  = (w_month > 4'd2) ? (r6_c - C_W'(YEAR_OFF_LATE))
                                      : (r6_c - C_W'(YEAR_OFF_EARLY));

    always_ff @(posedge i_clk) begin
        if (i_load[6]) begin
            r_year  <= w_year[YEAR_W-1:0];
            r_month <= w_month;
            r_day   <= w_day[DAY_W-1:0];
        end
    end

    assign o_year         = r_year;
    assign o_month        = r_month;
    assign o_day_of_month = r_day;

endmodule

@@ hw/rtl/mjdcal_time_pipe.sv @@
// Time path: day fraction to hour, minute, second and millisecond over seven stages.
module mjdcal_time_pipe (
    input  logic                                i_clk,
    input  mjdcal_pkg::t_stage_vec              i_load,
    input  logic [mjdcal_pkg::FRAC_W-1:0]       i_day_fraction,
    output logic [mjdcal_pkg::HOUR_W-1:0]       o_hour,
    output logic [mjdcal_pkg::MIN_W-1:0]        o_minute,
    output logic [mjdcal_pkg::SEC_W-1:0]        o_second,
    output logic [mjdcal_pkg::MSEC_W-1:0]       o_millisecond
);
    import mjdcal_pkg::*;

    // stage 1: ms = floor(fraction * 86400000 / 2^FRACTION_BITS)
    logic [FRAC_W-1:0]  w_frac;
    logic [PROD_W-1:0]  w_p1;
    logic [PROD_W-1:0]  w_p1_sh;
    logic [MS_W-1:0]    r1_ms;

    assign w_frac  = i_day_fraction & FRAC_MASK;
    assign w_p1    = PROD_W'(w_frac) * PROD_W'(MS_PER_DAY);
    assign w_p1_sh = w_p1 >> FRACTION_BITS;

    always_ff @(posedge i_clk) begin
        if (i_load[0]) begin
            r1_ms <= w_p1_sh[MS_W-1:0];
        end
    end

    // stage 2: whole seconds
    logic [MS_W+28-1:0] w_p2;
    logic [MS_W-1:0]    r2_ms;
    logic [QS_W-1:0]    r2_qs;

    assign w_p2 = (MS_W+28)'(r1_ms) * (MS_W+28)'(M_MS_TO_S);

    always_ff @(posedge i_clk) begin
        if (i_load[1]) begin
            r2_ms <= r1_ms;
            r2_qs <= w_p2[S_MS_TO_S +: QS_W];
        end
    end

    // stage 3: millisecond remainder
    logic [MS_W-1:0]    w_msec;
    logic [QS_W-1:0]    r3_qs;
    logic [MSEC_W-1:0]  r3_msec;

    assign w_msec = r2_ms - MS_W'(r2_qs) * MS_W'(MS_PER_S);

    always_ff @(posedge i_clk) begin
        if (i_load[2]) begin
            r3_qs   <= r2_qs;
            r3_msec <= w_msec[MSEC_W-1:0];
        end
    end

    // stage 4: whole minutes
    logic [QS_W+18-1:0] w_p4;
    logic [QS_W-1:0]    r4_qs;
    logic [QM_W-1:0]    r4_qm;
    logic [MSEC_W-1:0]  r4_msec;

    assign w_p4 = (QS_W+18)'(r3_qs) * (QS_W+18)'(M_S_TO_MIN);

    always_ff @(posedge i_clk) begin
        if (i_load[3]) begin
            r4_qs   <= r3_qs;
            r4_qm   <= w_p4[S_S_TO_MIN +: QM_W];
            r4_msec <= r3_msec;
        end
    end

    // stage 5: second remainder
    logic [QS_W-1:0]    w_sec;
    logic [QM_W-1:0]    r5_qm;
    logic [SEC_W-1:0]   r5_sec;
    logic [MSEC_W-1:0]  r5_msec;

    assign w_sec = r4_qs - QS_W'(r4_qm) * QS_W'(S_PER_MIN);

    always_ff @(posedge i_clk) begin
        if (i_load[4]) begin
            r5_qm   <= r4_qm;
            r5_sec  <= w_sec[SEC_W-1:0];
            r5_msec <= r4_msec;
        end
    end

    // stage 6: hours
    logic [QM_W+12-1:0] w_p6;
    logic [QM_W-1:0]    r6_qm;
    logic [HOUR_W-1:0]  r6_hour;
    logic [SEC_W-1:0]   r6_sec;
    logic [MSEC_W-1:0]  r6_msec;

    assign w_p6 = (QM_W+12)'(r5_qm) * (QM_W+12)'(M_MIN_TO_H);

    always_ff @(posedge i_clk) begin
        if (i_load[5]) begin
            r6_qm   <= r5_qm;
            r6_hour <= w_p6[S_MIN_TO_H +: HOUR_W];
            r6_sec  <= r5_sec;
            r6_msec <= r5_msec;
        end
    end

    // stage 7: minute remainder
    logic [QM_W-1:0]    w_min;
    logic [HOUR_W-1:0]  r_hour;
    logic [MIN_W-1:0]   r_minute;
    logic [SEC_W-1:0]   r_second;
    logic [MSEC_W-1:0]  r_msec;

    assign w_min = r6_qm - QM_W'(r6_hour) * QM_W'(MIN_PER_H);

    always_ff @(posedge i_clk) begin
        if (i_load[6]) begin
            r_hour   <= r6_hour;
            r_minute <= w_min[MIN_W-1:0];
            r_second <= r6_sec;
            r_msec   <= r6_msec;
        end
    end

    assign o_hour        = r_hour;
    assign o_minute      = r_minute;
    assign o_second      = r_second;
    assign o_millisecond = r_msec;

endmodule

@@ hw/rtl/mjd_to_calendar_date_unit.sv @@
// Top level of the MJD to calendar date and time-of-day converter.
// Converts a Modified Julian Date (signed whole days plus a binary day fraction) into
// year, month, day and time of day to the millisecond; days before JD 2299161 follow the
// Julian calendar, later ones the Gregorian. One transfer can be taken every clock while
// the output is not stalled, and each result passes through the seven register stages of
// the date path, which chains reciprocal multiplies for the century and year divisions,
// with the time path running alongside at equal depth. Every stage carries a valid bit
// and loads whenever it is empty or its successor moves, so a stall on the output only
// holds back stages that are full and empty slots keep filling. No state survives between
// items; reset clears only the valid bits.
module mjd_to_calendar_date_unit (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic signed [mjdcal_pkg::MJD_W-1:0]    i_mjd_day,
    input  logic        [mjdcal_pkg::FRAC_W-1:0]   i_day_fraction,
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic signed [mjdcal_pkg::YEAR_W-1:0]   o_year,
    output logic        [mjdcal_pkg::MONTH_W-1:0]  o_month,
    output logic        [mjdcal_pkg::DAY_W-1:0]    o_day_of_month,
    output logic        [mjdcal_pkg::HOUR_W-1:0]   o_hour,
    output logic        [mjdcal_pkg::MIN_W-1:0]    o_minute,
    output logic        [mjdcal_pkg::SEC_W-1:0]    o_second,
    output logic        [mjdcal_pkg::MSEC_W-1:0]   o_millisecond
);
    import mjdcal_pkg::*;

    t_stage_vec         w_load;
    logic [YEAR_W-1:0]  w_year;

    mjdcal_pipe_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_load  (w_load)
    );

    mjdcal_date_pipe u_date (
        .i_clk          (i_clk),
        .i_load         (w_load),
        .i_mjd_day      (i_mjd_day),
        .o_year         (w_year),
        .o_month        (o_month),
        .o_day_of_month (o_day_of_month)
    );

    mjdcal_time_pipe u_time (
        .i_clk          (i_clk),
        .i_load         (w_load),
        .i_day_fraction (i_day_fraction),
        .o_hour         (o_hour),
        .o_minute       (o_minute),
        .o_second       (o_second),
        .o_millisecond  (o_millisecond)
    );

    assign o_year = $signed(w_year);

endmodule

@@ hw/rtl/mjdcal_checker.sv @@
// Port-level checks of the MJD to calendar date unit, bound to the top level.
`include "mjd_to_calendar_date_unit_macros.svh"

module mjdcal_checker (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   o_stall,
    input  logic                                   o_valid,
    input  logic                                   i_stall,
    input  logic signed [mjdcal_pkg::YEAR_W-1:0]   o_year,
    input  logic        [mjdcal_pkg::MONTH_W-1:0]  o_month,
    input  logic        [mjdcal_pkg::DAY_W-1:0]    o_day_of_month,
    input  logic        [mjdcal_pkg::HOUR_W-1:0]   o_hour,
    input  logic        [mjdcal_pkg::MIN_W-1:0]    o_minute,
    input  logic        [mjdcal_pkg::SEC_W-1:0]    o_second,
    input  logic        [mjdcal_pkg::MSEC_W-1:0]   o_millisecond
);
    import mjdcal_pkg::*;

    // a stalled result holds until its transfer
    `MJDCAL_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_year) && $stable(o_month) && $stable(o_day_of_month) && $stable(o_hour) && $stable(o_minute) && $stable(o_second) && $stable(o_millisecond))

    // empty output stage means every stage can load
    `MJDCAL_ASSERT_NOW(a_no_stall_when_drained, i_clk, i_rst_n, !o_valid, !o_stall)

    // nothing comes out straight after reset
    `MJDCAL_ASSERT_NOW(a_empty_after_reset, i_clk, i_rst_n, $past(!i_rst_n), !o_valid)

    // exact divisions keep month, hour, minute, second and millisecond in their calendar ranges and the day at least 1
    `MJDCAL_ASSERT_NOW(a_field_range, i_clk, i_rst_n, o_valid, (o_month >= 4'd1) && (o_month <= 4'd12) && (o_day_of_month >= 5'd1) && (o_hour <= 5'd23) && (o_minute <= 6'd59) && (o_second <= 6'd59) && (o_millisecond <= 10'd999))

endmodule

bind mjd_to_calendar_date_unit mjdcal_checker u_checker (.*);
